@@ design/gev_pkg.sv @@
`timescale 1ns / 1ps
package gev_pkg;

  localparam int DEF_MAX_ACTIVE = 128;
  localparam int LBA_W = 64;
  localparam int CNT_W = 11;
  localparam int POS_W = 12;
  localparam int EB_W = 13;
  localparam int BSEEN_W = 23;
  localparam int TOTAL_W = 24;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [EB_W-1:0] MIN_ENTRY_BYTES = 13'd128;
  localparam logic [EB_W-1:0] MAX_ENTRY_BYTES = 13'd4096;
  localparam logic [CNT_W-1:0] MAX_ENTRY_TOTAL = 11'd1024;
  localparam logic [CNT_W-1:0] COUNT_SAT = 11'd2047;
  localparam logic [BSEEN_W-1:0] BYTES_SAT = 23'h7F_FFFF;

  // register indexes
  localparam logic [2:0] REG_FIRST_USABLE = 3'd0;
  localparam logic [2:0] REG_LAST_USABLE = 3'd1;
  localparam logic [2:0] REG_DISK_SECTORS = 3'd2;
  localparam logic [2:0] REG_ENTRY_BYTES = 3'd3;
  localparam logic [2:0] REG_ENTRY_TOTAL = 3'd4;
  localparam logic [2:0] REG_EXPECTED_CRC = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_USABLE = 3'd1;
  localparam logic [2:0] ST_SIZE = 3'd2;
  localparam logic [2:0] ST_CRC = 3'd3;
  localparam logic [2:0] ST_BOUNDS = 3'd4;
  localparam logic [2:0] ST_OVERLAP = 3'd5;
  localparam logic [2:0] ST_LENGTH = 3'd6;
  localparam logic [2:0] ST_FULL = 3'd7;

  // entry under check, walking down the cell chain
  typedef struct packed {
    logic             v;
    logic [LBA_W-1:0] s;
    logic [LBA_W-1:0] e;
    logic [CNT_W-1:0] cnt;
    logic             hit;
  } tok_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

@@ design/gev_cell.sv @@
`timescale 1ns / 1ps
module gev_cell import gev_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  tok_t tok_in,
  output tok_t tok_out
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [LBA_W-1:0] kept_s_r;
  logic [LBA_W-1:0] kept_e_r;
  tok_t             tok_r;
  tok_t             tok_nxt;
  logic             ovl;

  assign ovl = !(tok_in.e < kept_s_r || kept_e_r < tok_in.s);

  always_comb begin
    tok_nxt = tok_in;
    tok_nxt.hit = tok_in.hit | ((MY_IDX < tok_in.cnt) & ovl);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.v <= 1'b0;
    end else begin
      tok_r.v <= tok_in.v;
    end
    tok_r.s <= tok_nxt.s;
    tok_r.e <= tok_nxt.e;
    tok_r.cnt <= tok_nxt.cnt;
    tok_r.hit <= tok_nxt.hit;
    // the slot at the current fill count takes the new entry
    if (tok_in.v && tok_in.cnt == MY_IDX) begin
      kept_s_r <= tok_in.s;
      kept_e_r <= tok_in.e;
    end
  end

  assign tok_out = tok_r;

endmodule

@@ design/gpt_entry_array_validator.sv @@
`timescale 1ns / 1ps
// GPT partition entry array checker. Feed the array one byte per transaction,
// with in_tlast on the final byte; one status plus the active entry count comes
// out after it. Closing an active entry sends it down a chain of MAX_ACTIVE
// cells that hold the kept entries, one cell per cycle, and no new byte is
// taken until that walk ends. The final byte's result is registered once any
// such walk ends and busy clears; no new byte is taken until it is consumed.
module gpt_entry_array_validator import gev_pkg::*; #(
  parameter int MAX_ACTIVE = DEF_MAX_ACTIVE
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,   // end_of_array
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // status [2:0], active_entries [13:3], zero fill
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ACTIVE);

  logic [LBA_W-1:0]   first_usable_r, last_usable_r, disk_sectors_r;
  logic [EB_W-1:0]    entry_bytes_r;
  logic [CNT_W-1:0]   entry_total_r;
  logic [31:0]        expected_crc_r;
  logic [TOTAL_W-1:0] total_bytes;

  logic [31:0]        crc_r;
  logic [POS_W-1:0]   bie_r;
  logic [BSEEN_W-1:0] bseen_r;
  logic [LBA_W-1:0]   cur_s_r, cur_e_r;
  logic               cur_null_r;
  logic [CNT_W-1:0]   kept_count_r;
  logic [2:0]         first_err_r;
  logic               busy_r, pend_r, out_v_r;
  logic [2:0]         out_st_r;
  logic [CNT_W-1:0]   out_cnt_r;

  logic in_acc, size_ok, act, fin, launch, bound_bad;
  logic [2:0] status;
  tok_t chain [MAX_ACTIVE+1];
  tok_t tok_exit;

  assign total_bytes = TOTAL_W'(entry_total_r) * TOTAL_W'(entry_bytes_r);
  assign in_tready = !busy_r && !pend_r && !out_v_r;
  assign in_acc = in_tvalid && in_tready;
  assign size_ok = entry_bytes_r >= MIN_ENTRY_BYTES && entry_bytes_r <= MAX_ENTRY_BYTES;
  assign act = size_ok && ({1'b0, bseen_r} < total_bytes);
  assign fin = act && (({1'b0, bie_r} + 13'd1) >= entry_bytes_r);
  assign launch = in_acc && fin && !cur_null_r;
  assign bound_bad = cur_s_r > cur_e_r || cur_s_r < first_usable_r || cur_e_r > last_usable_r;

  always_comb begin
    chain[0].v = launch;
    chain[0].s = cur_s_r;
    chain[0].e = cur_e_r;
    chain[0].cnt = kept_count_r;
    chain[0].hit = 1'b0;
  end

  for (genvar i = 0; i < MAX_ACTIVE; i++) begin : g_cell
    gev_cell #(.IDX(i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tok_in (chain[i]),
      .tok_out(chain[i+1])
    );
  end

  assign tok_exit = chain[MAX_ACTIVE];

  always_comb begin
    if (first_usable_r > last_usable_r ||
        (disk_sectors_r != '0 && last_usable_r >= disk_sectors_r)) begin
      status = ST_USABLE;
    end else if (!size_ok || entry_total_r > MAX_ENTRY_TOTAL) begin
      status = ST_SIZE;
    end else if (~crc_r != expected_crc_r) begin
      status = ST_CRC;
    end else if ({1'b0, bseen_r} != total_bytes) begin
      status = ST_LENGTH;
    end else if (kept_count_r > MAX_CNT) begin
      status = ST_FULL;
    end else begin
      status = first_err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_usable_r <= '0;
      last_usable_r <= '0;
      disk_sectors_r <= '0;
      entry_bytes_r <= 13'd128;
      entry_total_r <= 11'd128;
      expected_crc_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_USABLE: first_usable_r <= cfg_wdata;
        REG_LAST_USABLE:  last_usable_r <= cfg_wdata;
        REG_DISK_SECTORS: disk_sectors_r <= cfg_wdata;
        REG_ENTRY_BYTES:  entry_bytes_r <= cfg_wdata[EB_W-1:0];
        REG_ENTRY_TOTAL:  entry_total_r <= cfg_wdata[CNT_W-1:0];
        REG_EXPECTED_CRC: expected_crc_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r == 1'b0 && pend_r && !busy_r) begin
      out_st_r <= status;
      out_cnt_r <= kept_count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '1;
      bie_r <= '0;
      bseen_r <= '0;
      cur_s_r <= '0;
      cur_e_r <= '0;
      cur_null_r <= 1'b1;
      kept_count_r <= '0;
      first_err_r <= ST_OK;
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (out_v_r && out_tready) begin
        out_v_r <= 1'b0;
      end
      if (tok_exit.v) begin
        busy_r <= 1'b0;
        if (tok_exit.hit && first_err_r == ST_OK) begin
          first_err_r <= ST_OVERLAP;
        end
      end
      if (in_acc) begin
        crc_r <= crc_byte(crc_r, in_tdata);
        if (bseen_r < BYTES_SAT) begin
          bseen_r <= bseen_r + 1'b1;
        end
        pend_r <= in_tlast;
        if (act) begin
          if (bie_r < 12'd16 && in_tdata != 8'd0) begin
            cur_null_r <= 1'b0;
          end else if (bie_r >= 12'd32 && bie_r < 12'd40) begin
            cur_s_r[8*bie_r[2:0] +: 8] <= in_tdata;
          end else if (bie_r >= 12'd40 && bie_r < 12'd48) begin
            cur_e_r[8*bie_r[2:0] +: 8] <= in_tdata;
          end
          if (fin) begin
            bie_r <= '0;
            cur_s_r <= '0;
            cur_e_r <= '0;
            cur_null_r <= 1'b1;
            if (!cur_null_r) begin
              busy_r <= 1'b1;
              if (bound_bad && first_err_r == ST_OK) begin
                first_err_r <= ST_BOUNDS;
              end
              if (kept_count_r < COUNT_SAT) begin
                kept_count_r <= kept_count_r + 1'b1;
              end
            end
          end else begin
            bie_r <= bie_r + 1'b1;
          end
        end else begin
          bie_r <= bie_r + 1'b1;
        end
      end
      // emit the status and start a fresh array
      if (!out_v_r && pend_r && !busy_r) begin
        out_v_r <= 1'b1;
        pend_r <= 1'b0;
        crc_r <= '1;
        bie_r <= '0;
        bseen_r <= '0;
        cur_s_r <= '0;
        cur_e_r <= '0;
        cur_null_r <= 1'b1;
        kept_count_r <= '0;
        first_err_r <= ST_OK;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = {2'b00, out_cnt_r, out_st_r};

  a_exit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tok_exit.v |-> busy_r) else $error("entry left the chain while idle");
  a_launch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    launch |=> busy_r) else $error("walk started without holding input");
  a_out_nopend: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> !pend_r && !busy_r) else $error("status emitted mid walk");

endmodule
